### rtl/bslpc_pkg.sv
// Package with the phase encoding, button codes and register reset values of the press classifier.
`default_nettype none

package bslpc_pkg;

	localparam int unsigned TickW = 16;
	localparam int unsigned NumButtons = 3;

	localparam logic [TickW-1:0] ShortTicksRst = 16'd451;
	localparam logic [TickW-1:0] LongTicksRst  = 16'd2001;
	localparam logic [TickW-1:0] TickMax       = 16'hFFFF;

	typedef logic [TickW-1:0] tick_t;
	typedef logic [NumButtons-1:0] btn_vec_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_SHORT = 3'b010,
		PH_LOCK  = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		BTN_ENTER = 2'd0,
		BTN_DOWN  = 2'd1,
		BTN_UP    = 2'd2
	} btn_id_t;

	// Configuration register indexes.
	localparam logic CFG_SHORT_TICKS = 1'b0;
	localparam logic CFG_LONG_TICKS  = 1'b1;

endpackage

`default_nettype wire

### rtl/button_short_long_press_classifier.sv
// Top level of the button press classifier: input register, phase machine and result register.
`default_nettype none

// One item is taken per clock cycle, every cycle, as long as the result register is not
// held by out_stall. An accepted item waits in the input register until the result
// register can advance, and the result register is then loaded from the phase logic.
// The rate is set by the update of the phase, tick counter and pending bits, done once
// per item. Each item is one tick: levels are active low (0 pressed), a fall sets a
// pending bit, and after short_ticks ticks the highest-priority pending button (enter,
// down, up) is reported as a long press if still held, else as a short press. Registers
// short_ticks (index 0) and long_ticks (index 1) are written through the cfg channel;
// the user must write them only while no item is in flight, not enforced by the block.
module button_short_long_press_classifier (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire                      enter_level,
	input  wire                      down_level,
	input  wire                      up_level,
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic [1:0]               button_id,
	output logic                     long_press,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire                      cfg_index,
	input  wire  [bslpc_pkg::TickW-1:0] cfg_data
);
	import bslpc_pkg::*;

	tick_t    short_ticks_q, long_ticks_q;
	btn_vec_t prev_q, pend_q;
	phase_t   phase_q;
	tick_t    tick_q;

	logic     s1_valid_q;
	btn_vec_t levels_s1;

	logic     out_valid_q;
	logic [1:0] out_id_q;
	logic     out_long_q;

	logic     adv, s1_fire;

	// Next-state logic.
	btn_vec_t pend_lat, pend_d;
	phase_t   phase_d;
	tick_t    tick_inc, tick_d, wait_len;
	logic     wait_done;
	logic     any_pend;
	logic [1:0] sel;
	btn_vec_t sel_mask;
	logic     res_valid, res_long;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = s1_valid_q && !adv;
	assign s1_fire   = s1_valid_q && adv;

	assign out_valid  = out_valid_q;
	assign button_id  = out_id_q;
	assign long_press = out_long_q;

	always_comb begin
		pend_lat = pend_q | (prev_q & ~levels_s1);
		any_pend = |pend_lat;
		priority if (pend_lat[0]) begin
			sel      = BTN_ENTER;
			sel_mask = 3'b001;
		end else if (pend_lat[1]) begin
			sel      = BTN_DOWN;
			sel_mask = 3'b010;
		end else if (pend_lat[2]) begin
			sel      = BTN_UP;
			sel_mask = 3'b100;
		end else begin
			sel      = BTN_ENTER;
			sel_mask = 3'b000;
		end

		// The counter saturates instead of wrapping.
		tick_inc  = (tick_q != TickMax) ? tick_q + 16'd1 : tick_q;
		wait_len  = (phase_q == PH_LOCK) ? long_ticks_q : short_ticks_q;
		wait_done = tick_inc >= wait_len;

		pend_d    = pend_lat;
		phase_d   = phase_q;
		tick_d    = tick_q;
		res_valid = 1'b0;
		res_long  = 1'b0;

		unique case (phase_q)
			PH_SHORT: begin
				tick_d = tick_inc;
				if (wait_done) begin
					tick_d = '0;
					if (!any_pend) begin
						phase_d = PH_LOCK;
					end else begin
						pend_d    = pend_lat & ~sel_mask;
						res_valid = 1'b1;
						res_long  = ~|(levels_s1 & sel_mask);
						phase_d   = res_long ? PH_LOCK : PH_IDLE;
					end
				end
			end
			PH_LOCK: begin
				tick_d = tick_inc;
				if (wait_done) begin
					tick_d  = '0;
					pend_d  = pend_lat & ~sel_mask;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (any_pend) begin
					phase_d = PH_SHORT;
					tick_d  = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_ticks_q <= ShortTicksRst;
			long_ticks_q  <= LongTicksRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SHORT_TICKS: short_ticks_q <= cfg_data;
				CFG_LONG_TICKS:  long_ticks_q  <= cfg_data;
				default:         short_ticks_q <= short_ticks_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			levels_s1 <= {up_level, down_level, enter_level};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '1;
			pend_q  <= '0;
			phase_q <= PH_SHORT;
			tick_q  <= '0;
		end else if (s1_fire) begin
			prev_q  <= levels_s1;
			pend_q  <= pend_d;
			phase_q <= phase_d;
			tick_q  <= tick_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_valid) begin
			out_id_q   <= sel;
			out_long_q <= res_long;
		end
	end

	// The input side only waits while a result is held in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled without a held result");

	// A long press always starts the lockout.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && res_valid && res_long) |=> (phase_q == PH_LOCK))
		else $error("long press did not enter lockout");

	// The tick counter is cleared whenever the block is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (tick_q == '0))
		else $error("tick counter nonzero in idle phase");

	// Only the three defined button codes are reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_id_q == BTN_ENTER || out_id_q == BTN_DOWN || out_id_q == BTN_UP))
		else $error("undefined button code reported");

endmodule

`default_nettype wire
